/* src/pcm2f_pkg.sv */
package pcm2f_pkg;

  // Sample format codes held in the sample_format register
  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_F32 = 3'd3,
    FMT_F64 = 3'd4
  } fmt_t;

  // Register word index (paddr[2])
  localparam logic REG_SAMPLE_FORMAT = 1'b0;

  // Fixed results
  localparam logic [31:0] U8_MIN_VALUE  = 32'hBF81_0204; // -128/127
  localparam logic [31:0] S16_MIN_VALUE = 32'hBF80_0100; // -32768/32767
  localparam logic [30:0] INF_MAG       = 31'h7F80_0000;
  localparam logic [30:0] QNAN_MAG      = 31'h7FC0_0000;

  // Bias difference between double and single exponents
  localparam logic [11:0] EXP_REBIAS    = 12'd896;

  // Count leading zeros of the 49-bit fixed-point magnitude
  function automatic logic [5:0] lzc49(input logic [48:0] x);
    logic [5:0] n;
    logic       hit;
    n   = 6'd0;
    hit = 1'b0;
    for (int i = 48; i >= 0; i--) begin
      if (!hit && x[i]) begin
        hit = 1'b1;
        n   = 6'(48 - i);
      end
    end
    return n;
  endfunction

endpackage

/* src/pcm_sample_to_float_unit.sv */
// PCM sample to single-precision float converter. One sample word enters per cycle
// (in_valid high, in_stall low) and its float result passes through an input
// decode register, a leading-zero / shift-amount stage, an alignment stage and
// the rounding stage that feeds the output register. A stall on the output freezes
// the whole pipeline and is passed back as in_stall. The user must change the
// format (sample_format at byte address 0: 0 u8, 1 s16, 2 s32, 3 f32, 4 f64,
// reset 1) only while the pipeline is empty; the block itself does not enforce
// it. Integer formats are converted as correctly rounded quotients (round to
// nearest even); doubles are rounded with subnormal, overflow and NaN handling.
module pcm_sample_to_float_unit (
  input  logic        clk,
  input  logic        rst,
  // sample input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] sample_word,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] float_bits,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pcm2f_pkg::fmt_t fmt;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pcm2f_pkg::REG_SAMPLE_FORMAT) ? {29'd0, fmt} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= pcm2f_pkg::FMT_S16;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == pcm2f_pkg::REG_SAMPLE_FORMAT) begin
      fmt <= pcm2f_pkg::fmt_t'(pwdata[2:0]);
    end
  end

  // Global advance: the pipeline moves unless the output is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 1: decode ----------------
  logic               d_direct;
  logic [31:0]        d_dval;
  logic               d_sign;
  logic               d_isint;
  logic [48:0]        d_m;
  logic               d_tail;
  logic signed [11:0] d_fexp;
  logic [52:0]        d_mant;
  logic [8:0]         u8_a;
  logic [8:0]         u8_mag;
  logic [15:0]        s16_mag;
  logic [31:0]        s32_mag;
  logic [10:0]        dexp;

  always_comb begin
    d_direct = 1'b0;
    d_dval   = 32'd0;
    d_sign   = 1'b0;
    d_isint  = 1'b1;
    d_m      = 49'd0;
    d_tail   = 1'b0;
    d_fexp   = 12'sd0;
    d_mant   = {1'b1, sample_word[51:0]};
    u8_a     = {1'b0, sample_word[7:0]} - 9'd128;
    u8_mag   = u8_a[8] ? (9'd0 - u8_a) : u8_a;
    s16_mag  = sample_word[15] ? (16'd0 - sample_word[15:0]) : sample_word[15:0];
    s32_mag  = sample_word[31] ? (32'd0 - sample_word[31:0]) : sample_word[31:0];
    dexp     = sample_word[62:52];
    case (fmt)
      pcm2f_pkg::FMT_U8: begin
        // |a|/127 is the 7-bit block repeated forever
        d_sign = u8_a[8];
        d_tail = 1'b1;
        if (u8_mag[7]) begin
          d_direct = 1'b1;
          d_dval   = pcm2f_pkg::U8_MIN_VALUE;
        end else begin
          d_m = 49'({1'b0, {7{u8_mag[6:0]}}} >> 1);
        end
      end
      pcm2f_pkg::FMT_S16: begin
        // |a|/32767 is the 15-bit block repeated forever
        d_sign = sample_word[15];
        d_tail = 1'b1;
        if (s16_mag[15]) begin
          d_direct = 1'b1;
          d_dval   = pcm2f_pkg::S16_MIN_VALUE;
        end else begin
          d_m = {1'b0, 48'({4{s16_mag[14:0]}} >> 12)};
        end
      end
      pcm2f_pkg::FMT_S32: begin
        d_sign = sample_word[31];
        d_m    = {s32_mag, 17'd0};
      end
      pcm2f_pkg::FMT_F32: begin
        d_direct = 1'b1;
        d_dval   = sample_word[31:0];
      end
      pcm2f_pkg::FMT_F64: begin
        d_isint = 1'b0;
        d_sign  = sample_word[63];
        d_fexp  = $signed({1'b0, dexp}) - $signed(pcm2f_pkg::EXP_REBIAS);
        if (dexp == 11'h7FF) begin
          d_direct = 1'b1;
          if (sample_word[51:0] == 52'd0) begin
            d_dval = {sample_word[63], pcm2f_pkg::INF_MAG};
          end else begin
            d_dval = {sample_word[63], pcm2f_pkg::QNAN_MAG | {8'd0, sample_word[51:29]}};
          end
        end else if (dexp == 11'd0) begin
          d_direct = 1'b1;
          d_dval   = {sample_word[63], 31'd0};
        end else if (d_fexp >= 12'sd255) begin
          d_direct = 1'b1;
          d_dval   = {sample_word[63], pcm2f_pkg::INF_MAG};
        end
      end
      default: begin
        d_direct = 1'b1;
        d_dval   = 32'd0;
      end
    endcase
  end

  logic               v1, direct1, sign1, isint1, tail1;
  logic [31:0]        dval1;
  logic [48:0]        m1;
  logic signed [11:0] fexp1;
  logic [52:0]        mant1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      direct1 <= d_direct;
      dval1   <= d_dval;
      sign1   <= d_sign;
      isint1  <= d_isint;
      m1      <= d_m;
      tail1   <= d_tail;
      fexp1   <= d_fexp;
      mant1   <= d_mant;
    end
  end

  // ---------------- stage 2: leading zeros / shift amount ----------------
  logic [6:0]  sh_full;
  logic        s2_direct;
  logic [31:0] s2_dval;

  always_comb begin
    sh_full   = (fexp1 >= 12'sd1) ? 7'd29 : 7'(12'sd30 - fexp1);
    s2_direct = direct1;
    s2_dval   = dval1;
    if (!direct1) begin
      if (isint1 && m1 == 49'd0) begin
        s2_direct = 1'b1;
        s2_dval   = 32'd0;
      end else if (!isint1 && (fexp1 < -12'sd33)) begin
        // shift beyond 63: rounds to signed zero
        s2_direct = 1'b1;
        s2_dval   = {sign1, 31'd0};
      end
    end
  end

  logic               v2, direct2, sign2, isint2, tail2;
  logic [31:0]        dval2;
  logic [48:0]        m2;
  logic [5:0]         lzc2, sh2;
  logic signed [11:0] fexp2;
  logic [52:0]        mant2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      direct2 <= s2_direct;
      dval2   <= s2_dval;
      sign2   <= sign1;
      isint2  <= isint1;
      tail2   <= tail1;
      m2      <= m1;
      lzc2    <= pcm2f_pkg::lzc49(m1);
      sh2     <= sh_full[5:0];
      fexp2   <= fexp1;
      mant2   <= mant1;
    end
  end

  // ---------------- stage 3: align ----------------
  logic [48:0]  mn;
  logic [116:0] ext;
  logic [23:0]  a_q;
  logic         a_g, a_st;
  logic [30:0]  a_base;

  always_comb begin
    mn  = m2 << lzc2;
    ext = {mant2, 64'd0} >> sh2;
    if (isint2) begin
      a_q    = mn[48:25];
      a_g    = mn[24];
      a_st   = (|mn[23:0]) | tail2;
      a_base = {8'(7'd126 - {1'b0, lzc2}), 23'd0};
    end else begin
      a_q    = ext[87:64];
      a_g    = ext[63];
      a_st   = |ext[62:0];
      a_base = (fexp2 >= 12'sd1) ? {8'(fexp2 - 12'sd1), 23'd0} : 31'd0;
    end
  end

  logic        v3, direct3, sign3, g3, st3;
  logic [31:0] dval3;
  logic [23:0] q3;
  logic [30:0] base3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      direct3 <= direct2;
      dval3   <= dval2;
      sign3   <= sign2;
      q3      <= a_q;
      g3      <= a_g;
      st3     <= a_st;
      base3   <= a_base;
    end
  end

  // ---------------- stage 4: round and pack ----------------
  logic        rnd;
  logic [31:0] rsum;
  logic [31:0] result;

  always_comb begin
    rnd  = g3 && (st3 || q3[0]);
    rsum = {1'b0, base3} + {8'd0, q3} + {31'd0, rnd};
    if (direct3) begin
      result = dval3;
    end else if (rsum >= {1'b0, pcm2f_pkg::INF_MAG}) begin
      result = {sign3, pcm2f_pkg::INF_MAG};
    end else begin
      result = {sign3, rsum[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      float_bits <= result;
    end
  end

endmodule
